// ===== sv/lzss4k_pkg.sv =====
// Shared types and constants for the 4 KiB window LZSS decoder.
package lzss4k_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int WIN_AW      = $clog2(WINDOW_SIZE);
    localparam int CNT_W       = 32;
    localparam int LEN_W       = 5;

    localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(4078);
    localparam logic [7:0]        FILL_BYTE = 8'h20;
    localparam logic [LEN_W-1:0]  MIN_MATCH = LEN_W'(3);

    localparam int USER_W     = 3;
    localparam int USER_VALID = 0;
    localparam int USER_FIN   = 1;
    localparam int USER_ERR   = 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR
    } t_state;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_HIGH
    } t_phase;

endpackage

// ===== sv/lzss4k_window.sv =====
// History window memory with fill tracking; unwritten entries read as spaces.
module lzss4k_window
    import lzss4k_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [WIN_AW-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [WIN_AW-1:0] i_rd_addr,
    input  logic [CNT_W-1:0]  i_fill,
    output logic [7:0]        o_rd_data
);

    logic [7:0]        r_mem [WINDOW_SIZE];
    logic [7:0]        r_q;
    logic              r_written;
    logic [WIN_AW-1:0] rel;
    logic              hit;

    assign rel = i_rd_addr - START_POS;
    assign hit = (i_fill[CNT_W-1:WIN_AW] != '0) || (rel < i_fill[WIN_AW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q       <= r_mem[i_rd_addr];
            r_written <= hit;
        end
    end

    assign o_rd_data = r_written ? r_q : FILL_BYTE;

endmodule

// ===== sv/lzss_4k_window_decoder.sv =====
// LZSS decoder top level: token parser, match copy sequencer and output register.
//
//   channel  | dir | handshake            | payload
//   s        | in  | i_s_tvalid/o_s_tready| tdata = in_byte, tlast = last_in
//   m        | out | o_m_tvalid/i_m_tready| tdata = out_byte, tuser, tlast = last_of_run
//   cfg      | in  | i_cfg_we             | i_cfg_wdata = expected_length
//
// A flag, literal or match-low beat is handled as it is accepted; a match high
// beat is accepted, then each copied byte takes a window read (S_RD), then emit
// and write back (S_WR). The window read and its registered data set this split.
// Reset is synchronous, active low; no clearing pass: a fill count marks which
// window entries hold data. A stalled output holds the sequencer in place.
module lzss_4k_window_decoder
    import lzss4k_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] in_byte
    input  logic              i_s_tlast,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // [7:0] out_byte
    output logic [USER_W-1:0] o_m_tuser,   // [0] byte_valid, [1] finished, [2] error
    output logic              o_m_tlast,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata
);

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [7:0]        r_flags, n_flags;
    logic [2:0]        r_idx, n_idx;
    logic [7:0]        r_held, n_held;
    logic [WIN_AW-1:0] r_wp, n_wp;
    logic [WIN_AW-1:0] r_pos, n_pos;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic              r_last, n_last;
    logic [CNT_W-1:0]  r_prod, n_prod;
    logic [CNT_W-1:0]  r_exp;

    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_obyte, n_obyte;
    logic [USER_W-1:0] r_ouser, n_ouser;
    logic              r_olast, n_olast;

    logic              out_free;
    logic              in_acc;
    logic              active;
    logic              fin;
    logic              copy_final;
    logic [CNT_W-1:0]  prod_inc;
    logic [7:0]        win_q;
    logic              wr_en;
    logic [7:0]        wr_data;

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign active     = r_prod < r_exp;
    assign prod_inc   = r_prod + CNT_W'(1);
    assign fin        = prod_inc == r_exp;
    assign copy_final = (r_cnt == LEN_W'(1)) || fin;

    lzss4k_window u_window (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (wr_data),
        .i_rd_en   (r_state == S_RD),
        .i_rd_addr (r_pos),
        .i_fill    (r_prod),
        .o_rd_data (win_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && active && r_phase == PH_HIGH) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (out_free) begin
                    n_state = copy_final ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        logic restart;
        logic emit;
        restart  = 1'b0;
        emit     = 1'b0;
        n_phase  = r_phase;
        n_flags  = r_flags;
        n_idx    = r_idx;
        n_held   = r_held;
        n_wp     = r_wp;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_prod   = r_prod;
        n_ovalid = r_ovalid && !i_m_tready;
        n_obyte  = r_obyte;
        n_ouser  = r_ouser;
        n_olast  = r_olast;
        wr_en    = 1'b0;
        wr_data  = i_s_tdata;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (active) begin
                        case (r_phase)
                            PH_FLAG: begin
                                n_flags = i_s_tdata;
                                n_idx   = '0;
                                n_phase = PH_TOKEN;
                            end
                            PH_TOKEN: begin
                                if (r_flags[r_idx]) begin
                                    emit    = 1'b1;
                                    wr_en   = 1'b1;
                                    wr_data = i_s_tdata;
                                    n_obyte = i_s_tdata;
                                    n_ouser = '0;
                                    n_ouser[USER_VALID] = 1'b1;
                                    n_ouser[USER_FIN]   = fin;
                                    n_ouser[USER_ERR]   = i_s_tlast && !fin;
                                    n_olast = 1'b1;
                                    n_idx   = r_idx + 3'd1;
                                    n_phase = (n_idx == 3'd0) ? PH_FLAG : PH_TOKEN;
                                end else begin
                                    n_held  = i_s_tdata;
                                    n_phase = PH_HIGH;
                                end
                            end
                            PH_HIGH: begin
                                n_pos  = {i_s_tdata[7:4], r_held};
                                n_cnt  = LEN_W'(i_s_tdata[3:0]) + MIN_MATCH;
                                n_last = i_s_tlast;
                            end
                            default: begin
                                n_phase = PH_FLAG;
                            end
                        endcase
                        if (i_s_tlast && r_phase != PH_HIGH && !emit) begin
                            n_ovalid = 1'b1;
                            n_obyte  = '0;
                            n_ouser  = '0;
                            n_ouser[USER_ERR] = 1'b1;
                            n_olast  = 1'b1;
                        end
                    end
                    if (i_s_tlast && !(active && r_phase == PH_HIGH)) begin
                        restart = 1'b1;
                    end
                end
            end
            S_WR: begin
                if (out_free) begin
                    emit    = 1'b1;
                    wr_en   = 1'b1;
                    wr_data = win_q;
                    n_obyte = win_q;
                    n_ouser = '0;
                    n_ouser[USER_VALID] = 1'b1;
                    n_ouser[USER_FIN]   = fin;
                    n_ouser[USER_ERR]   = copy_final && r_last && !fin;
                    n_olast = copy_final;
                    n_pos   = r_pos + WIN_AW'(1);
                    n_cnt   = r_cnt - LEN_W'(1);
                    if (copy_final) begin
                        n_idx   = r_idx + 3'd1;
                        n_phase = (n_idx == 3'd0) ? PH_FLAG : PH_TOKEN;
                        restart = r_last;
                    end
                end
            end
            default: begin
            end
        endcase

        if (emit) begin
            n_ovalid = 1'b1;
            n_wp     = r_wp + WIN_AW'(1);
            n_prod   = prod_inc;
        end

        if (restart) begin
            n_wp    = START_POS;
            n_flags = '0;
            n_idx   = '0;
            n_phase = PH_FLAG;
            n_prod  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_FLAG;
            r_flags  <= '0;
            r_idx    <= '0;
            r_wp     <= START_POS;
            r_cnt    <= '0;
            r_last   <= 1'b0;
            r_prod   <= '0;
            r_exp    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_flags  <= n_flags;
            r_idx    <= n_idx;
            r_wp     <= n_wp;
            r_cnt    <= n_cnt;
            r_last   <= n_last;
            r_prod   <= n_prod;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_exp <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held  <= n_held;
        r_pos   <= n_pos;
        r_obyte <= n_obyte;
        r_ouser <= n_ouser;
        r_olast <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_obyte;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the 4 KiB LZSS decoder: a table of directed beats, then random streams.
module tb_top
    import lzss4k_pkg::*;
();

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       fin;
        logic       err;
        logic       last;
    } t_dec_byte;

    typedef enum logic {ROW_CFG, ROW_BEAT} t_row_kind;
    typedef enum logic [1:0] {FEED_CLEAN, FEED_CUT, FEED_NOISE} t_feed_mode;

    typedef struct {
        t_row_kind   kind;
        logic [31:0] value;
        logic        last;
        logic        typed;
        t_dec_byte   want;
    } t_plan_row;

    localparam t_dec_byte NO_WANT  = '0;
    localparam int        PLAN_LEN = 34;
    localparam int        SETTLE   = 48;
    localparam int        HOLD_OFF = 400;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata = '0;
    logic              i_s_tlast = 1'b0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [7:0]        o_m_tdata;
    logic [USER_W-1:0] o_m_tuser;
    logic              o_m_tlast;
    logic              i_cfg_we = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;

    lzss_4k_window_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

    // decoder shadow state
    logic [7:0]        hist_win [WINDOW_SIZE];
    logic [WIN_AW-1:0] wr_ptr;
    logic [7:0]        flag_bits;
    logic [2:0]        flag_pos;
    t_phase            parse_at;
    logic [7:0]        copy_lo;
    logic [CNT_W-1:0]  out_count;
    logic [CNT_W-1:0]  target_len;

    t_dec_byte beat_bytes [$];
    t_dec_byte bytes_due [$];
    logic [3:0] copy_hi = '0;
    int  live_beats = 0;
    int  bad_count = 0;
    int  result_no = 0;
    bit  calm = 1'b0;
    bit  hold_off = 1'b0;
    bit  offering = 1'b0;

    function automatic void clear_stream();
        foreach (hist_win[k]) hist_win[k] = FILL_BYTE;
        wr_ptr    = START_POS;
        flag_bits = '0;
        flag_pos  = '0;
        parse_at  = PH_FLAG;
        copy_lo   = '0;
        out_count = '0;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        hist_win[wr_ptr] = b;
        wr_ptr    = wr_ptr + WIN_AW'(1);
        out_count = out_count + CNT_W'(1);
        beat_bytes.push_back('{b, 1'b1, out_count == target_len, 1'b0, 1'b0});
    endfunction

    function automatic void advance_token();
        flag_pos = flag_pos + 3'd1;
        parse_at = (flag_pos == 3'd0) ? PH_FLAG : PH_TOKEN;
    endfunction

    function automatic void decode_beat(input logic [7:0] b, input logic l);
        logic [WIN_AW-1:0] src;
        int                len;
        t_dec_byte         tail;
        beat_bytes.delete();
        if (out_count < target_len) begin
            case (parse_at)
                PH_FLAG: begin
                    flag_bits = b;
                    flag_pos  = '0;
                    parse_at  = PH_TOKEN;
                end
                PH_TOKEN: begin
                    if (flag_bits[flag_pos]) begin
                        put_byte(b);
                        advance_token();
                    end else begin
                        copy_lo  = b;
                        parse_at = PH_HIGH;
                    end
                end
                default: begin
                    len = int'(b[3:0]) + int'(MIN_MATCH);
                    src = {b[7:4], copy_lo};
                    for (int i = 0; i < len && out_count < target_len; i++)
                        put_byte(hist_win[src + WIN_AW'(i)]);
                    advance_token();
                end
            endcase
        end
        if (l) begin
            if (out_count < target_len) begin
                if (beat_bytes.size() == 0) beat_bytes.push_back(NO_WANT);
                tail = beat_bytes.pop_back();
                tail.err = 1'b1;
                beat_bytes.push_back(tail);
            end
            clear_stream();
        end
        if (beat_bytes.size() != 0) begin
            tail = beat_bytes.pop_back();
            tail.last = 1'b1;
            beat_bytes.push_back(tail);
        end
    endfunction

    // pick a byte that fits the parser's current phase
    function automatic logic [7:0] pick_byte();
        logic [WIN_AW-1:0] src;
        if (out_count >= target_len || parse_at == PH_FLAG) return 8'($urandom);
        if (parse_at == PH_HIGH) return {copy_hi, 4'($urandom)};
        if (flag_bits[flag_pos]) return 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            src = wr_ptr - WIN_AW'($urandom_range(1, 80));
        else
            src = WIN_AW'($urandom);
        copy_hi = src[11:8];
        return src[7:0];
    endfunction

    task automatic note_mismatch(input string what);
        bad_count++;
        $display("tb: mismatch at result %0d: %s", result_no, what);
    endtask

    task automatic hold_source();
        if (offering) i_s_tvalid <= 1'b0;
        offering = 1'b0;
    endtask

    task automatic wait_drained();
        hold_source();
        do @(posedge i_clk); while (bytes_due.size() != 0);
    endtask

    task automatic write_length(input logic [CNT_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        target_len = value;
    endtask

    task automatic send_beat(input logic [7:0] b, input logic l, input logic typed,
                             input t_dec_byte want);
        if (!calm && $urandom_range(0, 3) == 0) begin
            hold_source();
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= l;
        offering = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        if (out_count < target_len || l) live_beats++;
        decode_beat(b, l);
        if (typed)
            bytes_due.push_back(want);
        else
            foreach (beat_bytes[k]) bytes_due.push_back(beat_bytes[k]);
    endtask

    task automatic feed_stream(input t_feed_mode mode);
        int cap;
        int count;
        cap = (mode == FEED_CUT) ? $urandom_range(1, 12) :
              (mode == FEED_NOISE) ? $urandom_range(1, 10) : 80;
        count = 0;
        while (count < cap && (mode == FEED_NOISE || out_count < target_len)) begin
            send_beat((mode == FEED_NOISE) ? 8'($urandom) : pick_byte(), 1'b0, 1'b0, NO_WANT);
            count++;
        end
        if (mode == FEED_CLEAN)
            repeat ($urandom_range(0, 2)) send_beat(8'($urandom), 1'b0, 1'b0, NO_WANT);
        send_beat(pick_byte(), 1'b1, 1'b0, NO_WANT);
    endtask

    t_plan_row plan [PLAN_LEN] = '{
        '{ROW_BEAT, 32'hFF, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h00, 1'b1, 1'b0, NO_WANT},
        '{ROW_CFG,  32'd10, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'hED, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{ROW_BEAT, 32'hEE, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'hF2, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{ROW_BEAT, 32'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{ROW_BEAT, 32'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h0F, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h55, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'hAA, 1'b1, 1'b0, NO_WANT},
        '{ROW_CFG,  32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'hFF, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'hFF, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h12, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h30, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'hEE, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'hF0, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{ROW_BEAT, 32'h01, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h7F, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{ROW_BEAT, 32'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{ROW_CFG,  32'd5,  1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'hFF, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h41, 1'b0, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{ROW_BEAT, 32'h42, 1'b0, 1'b1, '{8'h42, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{ROW_CFG,  32'd1,  1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h43, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h44, 1'b1, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h01, 1'b0, 1'b0, NO_WANT},
        '{ROW_BEAT, 32'h5A, 1'b1, 1'b1, '{8'h5A, 1'b1, 1'b1, 1'b0, 1'b1}}
    };

    // sink: random stalls, one long hold-off on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    end

    // check each output beat against the oldest expected byte
    initial begin
        t_dec_byte seen;
        t_dec_byte want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                seen = '{o_m_tdata, o_m_tuser[USER_VALID], o_m_tuser[USER_FIN],
                         o_m_tuser[USER_ERR], o_m_tlast};
                @(negedge i_clk);
                result_no++;
                if (bytes_due.size() == 0) begin
                    note_mismatch("output beat with nothing expected");
                end else begin
                    want = bytes_due.pop_front();
                    if (seen.data !== want.data)
                        note_mismatch($sformatf("out_byte %02h, expected %02h",
                                                seen.data, want.data));
                    if (seen.valid !== want.valid)
                        note_mismatch($sformatf("byte_valid %0b, expected %0b",
                                                seen.valid, want.valid));
                    if (seen.fin !== want.fin)
                        note_mismatch($sformatf("finished %0b, expected %0b",
                                                seen.fin, want.fin));
                    if (seen.err !== want.err)
                        note_mismatch($sformatf("error %0b, expected %0b",
                                                seen.err, want.err));
                    if (seen.last !== want.last)
                        note_mismatch($sformatf("last_of_run %0b, expected %0b",
                                                seen.last, want.last));
                end
            end
        end
    end

    initial begin
        int         pick;
        int         stream_no;
        logic [31:0] len;
        target_len = '0;
        clear_stream();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG)
                write_length(plan[k].value);
            else
                send_beat(plan[k].value[7:0], plan[k].last, plan[k].typed, plan[k].want);
        end

        // fill the block while the sink holds off
        write_length(32'd250);
        hold_off = 1'b1;
        feed_stream(FEED_CLEAN);

        stream_no = 0;
        while (live_beats < 470) begin
            stream_no++;
            if (stream_no == 12) wait_drained();
            if (live_beats >= 400) calm = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = '0;
            else if (pick == 1)
                len = $urandom;
            else if (pick <= 3)
                len = $urandom_range(100, 300);
            else
                len = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) write_length(len);
            pick = $urandom_range(0, 9);
            feed_stream(pick == 0 ? FEED_NOISE : pick == 1 ? FEED_CUT : FEED_CLEAN);
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (bad_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== lzss_4k_window_decoder.f =====
sv/lzss4k_pkg.sv
sv/lzss4k_window.sv
sv/lzss_4k_window_decoder.sv
tb/tb_top.sv
